### rtl/core/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants of the tick timeout scheduler
// Field widths, table sizing, request and result types, and the helper
// functions for wrap-safe deadline order and circular table indexing.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

  // Table and burst sizing.
  localparam int QUEUE_DEPTH = 16;
  localparam int HANDLE_BITS = 8;
  localparam int MAX_RESULTS = 16;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int RES_W = $clog2(MAX_RESULTS + 1);

  // Fixed port field widths.
  localparam int KIND_W    = 2;
  localparam int DELAY_W   = 31;
  localparam int OHANDLE_W = 8;
  localparam int TICK_W    = 32;

  // Depth of the request queue between front and back.
  localparam int REQ_Q_DEPTH = 2;
  localparam int REQ_Q_PTR_W = $clog2(REQ_Q_DEPTH);
  localparam int REQ_Q_CNT_W = $clog2(REQ_Q_DEPTH + 1);

  // Request kind codes as they arrive on the input channel.
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELAY = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_ADD,
    OP_DELAY,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [DELAY_W-1:0]     delay;
    logic [HANDLE_BITS-1:0] handle;
  } req_t;

  typedef struct packed {
    logic                 fired;
    logic [OHANDLE_W-1:0] fired_handle;
    logic                 last;
    logic [TICK_W-1:0]    tick_count;
    logic                 delay_active;
    logic                 status;
  } res_t;

  // True when a lies strictly after b in wrap-safe signed order.
  function automatic logic is_after(input logic [TICK_W-1:0] a,
                                    input logic [TICK_W-1:0] b);
    logic [TICK_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[TICK_W-1];
  endfunction

  // Physical table slot that lies off places behind base, around the ring.
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return IDX_W'(sum);
  endfunction

  // Handle as kept in the table, from the input field.
  function automatic logic [HANDLE_BITS-1:0] to_table_handle(
      input logic [OHANDLE_W-1:0] h);
    logic [15:0] wide;
    wide = 16'(h);
    return wide[HANDLE_BITS-1:0];
  endfunction

  // Handle as reported on the result channel, from a table entry.
  function automatic logic [OHANDLE_W-1:0] to_port_handle(
      input logic [HANDLE_BITS-1:0] h);
    logic [15:0] wide;
    wide = 16'(h);
    return wide[OHANDLE_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/tts_if.sv
// ----------------------------------------------------------------------------
// tts_if: request and result channel interfaces
// Valid/ready channels carrying the scheduler's input and result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface tts_in_if;
  import tts_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [DELAY_W-1:0]   delay_ticks;
  logic [OHANDLE_W-1:0] action_handle;

  modport source (output valid, kind, delay_ticks, action_handle, input ready);
  modport sink   (input valid, kind, delay_ticks, action_handle, output ready);
endinterface

interface tts_out_if;
  import tts_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 fired;
  logic [OHANDLE_W-1:0] fired_handle;
  logic                 last;
  logic [TICK_W-1:0]    tick_count;
  logic                 delay_active;
  logic                 status;

  modport source (output valid, fired, fired_handle, last, tick_count,
                  delay_active, status, input ready);
  modport sink   (input valid, fired, fired_handle, last, tick_count,
                  delay_active, status, output ready);
endinterface

`default_nettype wire

### rtl/core/tts_front.sv
// ----------------------------------------------------------------------------
// tts_front: request intake and classification
// Decodes the request kind into an operation and trims the handle to the
// width kept in the timeout table.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_front (
  tts_in_if.sink        in_bus,
  output logic          req_valid,
  input  logic          req_ready,
  output tts_pkg::req_t req
);
  import tts_pkg::*;

  op_t op;

  always_comb begin
    unique case (in_bus.kind)
      KIND_TICK:  op = OP_TICK;
      KIND_ADD:   op = OP_ADD;
      KIND_DELAY: op = OP_DELAY;
      default:    op = OP_NOP;
    endcase
  end

  assign req.op     = op;
  assign req.delay  = in_bus.delay_ticks;
  assign req.handle = to_table_handle(in_bus.action_handle);

  assign req_valid    = in_bus.valid;
  assign in_bus.ready = req_ready;

endmodule

`default_nettype wire

### rtl/core/tts_fifo.sv
// ----------------------------------------------------------------------------
// tts_fifo: request queue between front and back
// A short first-in first-out queue of classified requests.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  tts_pkg::req_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output tts_pkg::req_t pop_data
);
  import tts_pkg::*;

  req_t                   slot_r [REQ_Q_DEPTH];
  logic [REQ_Q_PTR_W-1:0] wr_ptr_r;
  logic [REQ_Q_PTR_W-1:0] rd_ptr_r;
  logic [REQ_Q_CNT_W-1:0] cnt_r;
  logic                   do_push;
  logic                   do_pop;

  function automatic logic [REQ_Q_PTR_W-1:0] ptr_inc(input logic [REQ_Q_PTR_W-1:0] p);
    return (p == REQ_Q_PTR_W'(REQ_Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready = (cnt_r != REQ_Q_CNT_W'(REQ_Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tts_back.sv
// ----------------------------------------------------------------------------
// tts_back: timer engine
// Holds the tick counter, the delay countdown and the deadline-ordered
// timeout ring, carries out one request at a time and drives the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  output logic          req_ready,
  input  tts_pkg::req_t req,
  tts_out_if.source     out_bus
);
  import tts_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_INS
  } state_t;

  state_t                 state_r, state_nxt;
  logic [TICK_W-1:0]      tc_r, tc_nxt;
  logic [TICK_W-1:0]      dr_r, dr_nxt;
  logic [IDX_W-1:0]       head_r, head_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]       walk_r, walk_nxt;
  logic [TICK_W-1:0]      dl_new_r, dl_new_nxt;
  logic [HANDLE_BITS-1:0] hnd_new_r, hnd_new_nxt;
  logic [RES_W-1:0]       nres_r, nres_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [HANDLE_BITS-1:0] pend_h_r, pend_h_nxt;
  logic                   out_v_r, out_v_nxt;
  res_t                   res_r, res_nxt;

  // Timeout ring: entries head_r .. head_r+cnt_r-1 are live, oldest deadline first.
  logic [TICK_W-1:0]      ent_dl_r [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] ent_id_r [QUEUE_DEPTH];

  logic [IDX_W-1:0]       rd_idx;
  logic [TICK_W-1:0]      rd_dl;
  logic [HANDLE_BITS-1:0] rd_id;
  logic                   tbl_we;
  logic [IDX_W-1:0]       tbl_widx;
  logic [TICK_W-1:0]      tbl_wdl;
  logic [HANDLE_BITS-1:0] tbl_wid;
  logic                   out_free;
  logic                   head_due;
  logic                   pop_head;
  logic [TICK_W-1:0]      add_dl;

  assign out_free = !out_v_r || out_bus.ready;

  // One read port: the head while ticking, the walk position while inserting.
  assign rd_idx = (state_r == ST_INS) ? wrap_idx(head_r, CNT_W'(walk_r - 1'b1)) : head_r;
  assign rd_dl  = ent_dl_r[rd_idx];
  assign rd_id  = ent_id_r[rd_idx];

  assign head_due = (cnt_r != '0) && (nres_r < RES_W'(MAX_RESULTS)) &&
                    !is_after(rd_dl, tc_r);
  assign add_dl   = tc_r + TICK_W'(req.delay);

  always_comb begin
    state_nxt   = state_r;
    tc_nxt      = tc_r;
    dr_nxt      = dr_r;
    head_nxt    = head_r;
    cnt_nxt     = cnt_r;
    walk_nxt    = walk_r;
    dl_new_nxt  = dl_new_r;
    hnd_new_nxt = hnd_new_r;
    nres_nxt    = nres_r;
    pend_v_nxt  = pend_v_r;
    pend_h_nxt  = pend_h_r;
    out_v_nxt   = out_bus.ready ? 1'b0 : out_v_r;
    res_nxt     = res_r;
    req_ready   = 1'b0;
    tbl_we      = 1'b0;
    tbl_widx    = wrap_idx(head_r, walk_r);
    tbl_wdl     = rd_dl;
    tbl_wid     = rd_id;
    pop_head    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        req_ready = out_free;
        if (req_valid && out_free) begin
          unique case (req.op)
            OP_TICK: begin
              tc_nxt     = tc_r + 1'b1;
              dr_nxt     = (dr_r != '0) ? dr_r - 1'b1 : dr_r;
              nres_nxt   = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = ST_TICK;
            end
            OP_ADD: begin
              if (cnt_r == CNT_W'(QUEUE_DEPTH)) begin
                out_v_nxt      = 1'b1;
                res_nxt        = '0;
                res_nxt.last   = 1'b1;
                res_nxt.status = 1'b1;
              end else begin
                dl_new_nxt  = add_dl;
                hnd_new_nxt = req.handle;
                walk_nxt    = cnt_r;
                state_nxt   = ST_INS;
              end
            end
            OP_DELAY: begin
              dr_nxt       = TICK_W'(req.delay);
              out_v_nxt    = 1'b1;
              res_nxt      = '0;
              res_nxt.last = 1'b1;
            end
            OP_NOP: begin
              out_v_nxt    = 1'b1;
              res_nxt      = '0;
              res_nxt.last = 1'b1;
            end
            default: ;
          endcase
        end
      end

      ST_TICK: begin
        // A popped entry waits in the pending slot until the next head is
        // judged, so that the final result of the burst carries last.
        if (head_due) begin
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              out_v_nxt            = 1'b1;
              res_nxt              = '0;
              res_nxt.fired        = 1'b1;
              res_nxt.fired_handle = to_port_handle(pend_h_r);
            end
            pop_head   = 1'b1;
            pend_v_nxt = 1'b1;
            pend_h_nxt = rd_id;
            head_nxt   = wrap_idx(head_r, CNT_W'(1));
            cnt_nxt    = cnt_r - 1'b1;
            nres_nxt   = nres_r + 1'b1;
          end
        end else if (out_free) begin
          out_v_nxt            = 1'b1;
          res_nxt              = '0;
          res_nxt.fired        = pend_v_r;
          res_nxt.fired_handle = pend_v_r ? to_port_handle(pend_h_r) : '0;
          res_nxt.last         = 1'b1;
          pend_v_nxt           = 1'b0;
          state_nxt            = ST_IDLE;
        end
      end

      ST_INS: begin
        // Walk from the tail: each later entry moves back one slot.
        if ((walk_r != '0) && is_after(rd_dl, dl_new_r)) begin
          tbl_we   = 1'b1;
          walk_nxt = walk_r - 1'b1;
        end else if (out_free) begin
          tbl_we       = 1'b1;
          tbl_wdl      = dl_new_r;
          tbl_wid      = hnd_new_r;
          cnt_nxt      = cnt_r + 1'b1;
          out_v_nxt    = 1'b1;
          res_nxt      = '0;
          res_nxt.last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    res_nxt.tick_count   = out_v_nxt && !out_v_r ? tc_nxt : res_nxt.tick_count;
    if (out_v_nxt && (out_free)) begin
      res_nxt.tick_count   = tc_nxt;
      res_nxt.delay_active = (dr_nxt != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      tc_r     <= '0;
      dr_r     <= '0;
      head_r   <= '0;
      cnt_r    <= '0;
      nres_r   <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tc_r     <= tc_nxt;
      dr_r     <= dr_nxt;
      head_r   <= head_nxt;
      cnt_r    <= cnt_nxt;
      nres_r   <= nres_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    walk_r    <= walk_nxt;
    dl_new_r  <= dl_new_nxt;
    hnd_new_r <= hnd_new_nxt;
    pend_h_r  <= pend_h_nxt;
    res_r     <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      ent_dl_r[tbl_widx] <= tbl_wdl;
      ent_id_r[tbl_widx] <= tbl_wid;
    end
  end

  assign out_bus.valid        = out_v_r;
  assign out_bus.fired        = res_r.fired;
  assign out_bus.fired_handle = res_r.fired_handle;
  assign out_bus.last         = res_r.last;
  assign out_bus.tick_count   = res_r.tick_count;
  assign out_bus.delay_active = res_r.delay_active;
  assign out_bus.status       = res_r.status;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("timeout table count exceeds its depth");

  a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nres_r <= RES_W'(MAX_RESULTS))
    else $error("tick burst exceeds the result limit");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    pop_head |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("head pop did not shrink the table");

  a_counter_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |=> $stable(tc_r))
    else $error("tick counter moved while a request was in progress");

  a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.fired |-> !res_r.status)
    else $error("fired result carries a reject status");
`endif

endmodule

`default_nettype wire

### rtl/core/tick_timeout_scheduler.sv
// Flow: a request is registered in the queue before the timer engine takes it; a delay
// or unused request then sets the result register, an add first walks past each pending
// entry with a later deadline, and a tick first fires each due entry, up to MAX_RESULTS.
// Throughput: one request at a time in the engine, one table entry walked per cycle, and
// one fired per cycle while the result channel is not stalled; a two-entry queue buffers
// intake.
// ----------------------------------------------------------------------------
// tick_timeout_scheduler: tick-driven timeout scheduler
// Keeps a free-running tick counter, a delay countdown and a deadline-ordered
// table of pending timeouts, and reports expired handles on every tick.
// ----------------------------------------------------------------------------
`default_nettype none

// Reset is synchronous and active low: counter, countdown and table fill go to zero.
// Structure: the front classifies each incoming request, a short queue
// decouples intake from execution, and the back engine carries requests out.
// The table is a ring of QUEUE_DEPTH slots; firing advances the head, while
// an add walks back from the tail one slot per cycle, moving each entry with
// a later deadline up by one, so equal deadlines stay in arrival order.
// Deadlines are compared in wrap-safe signed order against the counter.
// Table contents have no reset; only slots inside the live window are read,
// so no clearing pass is needed after reset.
module tick_timeout_scheduler (
  input  logic       clk,
  input  logic       rst_n,
  tts_in_if.sink     in_bus,
  tts_out_if.source  out_bus
);
  import tts_pkg::*;

  logic front_valid;
  logic front_ready;
  req_t front_req;
  logic back_valid;
  logic back_ready;
  req_t back_req;

  // Intake: decode the request kind and trim the handle.
  tts_front u_front (
    .in_bus    (in_bus),
    .req_valid (front_valid),
    .req_ready (front_ready),
    .req       (front_req)
  );

  // Request queue: lets intake keep going while the engine walks the table.
  tts_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_req),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_req)
  );

  // Engine: counter, countdown, timeout ring and result register.
  tts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (back_valid),
    .req_ready (back_ready),
    .req       (back_req),
    .out_bus   (out_bus)
  );

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the tick timeout scheduler
// Requests come from a queue that an initial block fills. A clocked driver
// presents them with random gaps, and a clocked monitor takes results with
// random stalls. Every accepted request runs through a timer model of this
// bench, which keeps its own tick counter, countdown and deadline-ordered
// table. The model's results are compared field by field with the block's.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import tts_pkg::*;

  // Kind code 3 is not assigned and has to be ignored by the block.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // CYCLE_LIMIT lies well above the slowest run the bench can make: near 200
  // requests, each with the longest input gap and up to 16 results that each
  // wait out the longest result stall.
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_REQS = 145;
  localparam int CALM_FROM = 115;
  localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [DELAY_W-1:0]   delay;
    logic [OHANDLE_W-1:0] handle;
    logic                 calm;   // no idling on either side from here on
  } timer_req_t;

  typedef struct packed {
    logic [TICK_W-1:0]      deadline;
    logic [HANDLE_BITS-1:0] handle;
  } armed_timer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tts_in_if  in_bus ();
  tts_out_if out_bus ();

  tick_timeout_scheduler u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Requests waiting for the driver, and the request on the bus right now.
  timer_req_t pending_reqs[$];
  timer_req_t driven_req;
  bit         req_taken;

  // Timer model state, as the block should hold it after every request.
  logic [TICK_W-1:0] model_ticks;
  logic [TICK_W-1:0] model_delay_left;
  armed_timer_t      armed_timers[$];

  // Results that the block still owes, oldest first.
  res_t due_results[$];

  int  error_count;
  int  cycle_count;
  int  accepted_reqs;
  int  results_checked;
  int  fired_count;
  int  reject_count;
  int  longest_burst;
  bit  quiet;
  int  in_gap;
  int  out_stall;

  // Strictly later in wrap-safe order: the difference is nonzero and its
  // sign bit is clear.
  function automatic bit deadline_later(input logic [TICK_W-1:0] a,
                                        input logic [TICK_W-1:0] b);
    logic [TICK_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[TICK_W-1];
  endfunction

  // Advances the timer model by one request and queues the results that the
  // block has to produce for it.
  function automatic void predict_timer_results(input timer_req_t r);
    res_t              res;
    armed_timer_t      ent;
    logic [TICK_W-1:0] dl;
    int                pos;
    int                n;
    bit                rejected;
    rejected = 1'b0;
    if (r.kind == KIND_TICK) begin
      model_ticks = model_ticks + 1'b1;
      if (model_delay_left != '0) begin
        model_delay_left = model_delay_left - 1'b1;
      end
      // Fire every head entry that is due, at most MAX_RESULTS per tick; the
      // rest stay at the head and fire on the next tick.
      n = 0;
      while (n < MAX_RESULTS && armed_timers.size() > 0 &&
             !deadline_later(armed_timers[0].deadline, model_ticks)) begin
        ent = armed_timers.pop_front();
        res = '0;
        res.fired = 1'b1;
        res.fired_handle = OHANDLE_W'(ent.handle);
        res.tick_count = model_ticks;
        res.delay_active = (model_delay_left != '0);
        due_results.push_back(res);
        n++;
      end
      if (n > longest_burst) begin
        longest_burst = n;
      end
      if (n > 0) begin
        due_results[due_results.size() - 1].last = 1'b1;
        return;
      end
    end else if (r.kind == KIND_ADD) begin
      if (armed_timers.size() >= QUEUE_DEPTH) begin
        rejected = 1'b1;
        reject_count++;
      end else begin
        // Insert behind every entry that is not later, so equal deadlines
        // keep their arrival order.
        dl = model_ticks + TICK_W'(r.delay);
        pos = 0;
        while (pos < armed_timers.size() &&
               !deadline_later(armed_timers[pos].deadline, dl)) begin
          pos++;
        end
        ent.deadline = dl;
        ent.handle = HANDLE_BITS'(r.handle);
        armed_timers.insert(pos, ent);
      end
    end else if (r.kind == KIND_DELAY) begin
      model_delay_left = TICK_W'(r.delay);
    end
    // Every request other than a tick that fired gives one plain result.
    res = '0;
    res.last = 1'b1;
    res.tick_count = model_ticks;
    res.delay_active = (model_delay_left != '0);
    res.status = rejected;
    due_results.push_back(res);
  endfunction

  function automatic void check_field(input string name,
                                      input logic [TICK_W-1:0] exp_val,
                                      input logic [TICK_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: result %0d, %s mismatch: expected %0h, actual %0h",
               $time, results_checked, name, exp_val, act_val);
      error_count++;
    end
  endfunction

  // Everything is sampled at the rising edge. A request taken at this edge
  // is predicted before any of its results can show.
  always @(posedge clk) begin
    res_t exp_res;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("*** FAILED ***");
      $finish;
    end else if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        predict_timer_results(driven_req);
        accepted_reqs++;
        req_taken = 1'b1;
        if (driven_req.calm) begin
          quiet = 1'b1;
        end
      end
      if (out_bus.valid && out_bus.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual fired=%0b",
                   $time, out_bus.fired, " handle=%0h last=%0b tick=%0h",
                   out_bus.fired_handle, out_bus.last, out_bus.tick_count,
                   " delay_active=%0b status=%0b",
                   out_bus.delay_active, out_bus.status);
          error_count++;
        end else begin
          exp_res = due_results.pop_front();
          check_field("fired", TICK_W'(exp_res.fired), TICK_W'(out_bus.fired));
          check_field("fired_handle", TICK_W'(exp_res.fired_handle),
                      TICK_W'(out_bus.fired_handle));
          check_field("last", TICK_W'(exp_res.last), TICK_W'(out_bus.last));
          check_field("tick_count", exp_res.tick_count, out_bus.tick_count);
          check_field("delay_active", TICK_W'(exp_res.delay_active),
                      TICK_W'(out_bus.delay_active));
          check_field("status", TICK_W'(exp_res.status), TICK_W'(out_bus.status));
          if (exp_res.fired) begin
            fired_count++;
          end
        end
        results_checked++;
      end
    end
  end

  // Request driver, on the falling edge. A request on the bus stays there
  // until it is taken; gaps only start between requests.
  always @(negedge clk) begin
    logic       next_valid;
    timer_req_t next_req;
    next_valid = 1'b0;
    next_req = driven_req;
    if (rst_n) begin
      if (req_taken) begin
        void'(pending_reqs.pop_front());
        req_taken = 1'b0;
      end else if (in_bus.valid) begin
        next_valid = 1'b1;
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_reqs.size() > 0 && !pending_reqs[0].calm &&
                     $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 13);
        end else if (pending_reqs.size() > 0) begin
          next_valid = 1'b1;
          next_req = pending_reqs[0];
        end
      end
    end
    driven_req = next_req;
    in_bus.valid <= next_valid;
    in_bus.kind <= next_req.kind;
    in_bus.delay_ticks <= next_req.delay;
    in_bus.action_handle <= next_req.handle;
  end

  // Result stalls, on the falling edge: bursts of random length with ready
  // low, none once the calm tail of the run has started.
  always @(negedge clk) begin
    logic next_ready;
    next_ready = 1'b1;
    if (!rst_n) begin
      next_ready = 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      next_ready = 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_stall = $urandom_range(0, 13);
      next_ready = 1'b0;
    end
    out_bus.ready <= next_ready;
  end

  function automatic void queue_req(input logic [KIND_W-1:0] kind,
                                    input logic [DELAY_W-1:0] delay,
                                    input logic [OHANDLE_W-1:0] handle,
                                    input bit calm);
    timer_req_t r;
    r.kind = kind;
    r.delay = delay;
    r.handle = handle;
    r.calm = calm;
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [DELAY_W-1:0] random_delay();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      return DELAY_W'($urandom_range(0, 12));
    end else if (pick < 92) begin
      return DELAY_W'($urandom_range(13, 300));
    end
    return DELAY_W'($urandom);
  endfunction

  initial begin
    int       issued;
    int       burst_len;
    int       pick;
    bit       calm;
    in_bus.valid = 1'b0;
    in_bus.kind = KIND_TICK;
    in_bus.delay_ticks = '0;
    in_bus.action_handle = '0;
    out_bus.ready = 1'b0;
    driven_req = '0;
    req_taken = 1'b0;
    model_ticks = '0;
    model_delay_left = '0;
    error_count = 0;
    cycle_count = 0;
    accepted_reqs = 0;
    results_checked = 0;
    fired_count = 0;
    reject_count = 0;
    longest_burst = 0;
    quiet = 1'b0;
    in_gap = 0;
    out_stall = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. A tick on an empty table, an unused kind with every
    // field bit set, countdown loads at both ends of the range.
    queue_req(KIND_TICK, '0, '0, 1'b0);
    queue_req(KIND_UNUSED, DELAY_MAX, 8'hFF, 1'b0);
    queue_req(KIND_DELAY, DELAY_MAX, 8'h00, 1'b0);
    queue_req(KIND_DELAY, '0, 8'hFF, 1'b0);
    queue_req(KIND_DELAY, 31'd3, 8'h3C, 1'b0);
    // Fill the table with deadlines of now and now + 1 in alternating order,
    // handles 0 through 255 in steps of 17, so sorting and arrival order both matter.
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue_req(KIND_ADD, DELAY_W'((i + 1) % 2), OHANDLE_W'(i * 17), 1'b0);
    end
    // The table is full now, so this add is rejected.
    queue_req(KIND_ADD, 31'd5, 8'hA5, 1'b0);
    // One tick fires the whole table in a single maximal burst.
    queue_req(KIND_TICK, '0, '0, 1'b0);
    // Largest offset: still strictly later in wrap-safe order, so the tick below does not fire it.
    queue_req(KIND_ADD, DELAY_MAX, 8'h5A, 1'b0);
    queue_req(KIND_TICK, DELAY_MAX, 8'hFF, 1'b0);

    // Hold back new requests until the block has answered everything.
    while (pending_reqs.size() != 0 || due_results.size() != 0) begin
      @(posedge clk);
    end

    // Random part: mostly single requests, with bursts of short adds that a tick
    // then follows, firing together those that are due.
    issued = 0;
    while (issued < RANDOM_REQS) begin
      calm = (issued >= CALM_FROM);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        burst_len = $urandom_range(2, 8);
        for (int i = 0; i < burst_len; i++) begin
          queue_req(KIND_ADD, DELAY_W'($urandom_range(0, 3)),
                    OHANDLE_W'($urandom), calm);
        end
        queue_req(KIND_TICK, DELAY_W'($urandom), OHANDLE_W'($urandom), calm);
        issued += burst_len + 1;
      end else if (pick < 55) begin
        queue_req(KIND_TICK, DELAY_W'($urandom), OHANDLE_W'($urandom), calm);
        issued++;
      end else if (pick < 85) begin
        queue_req(KIND_ADD, random_delay(), OHANDLE_W'($urandom), calm);
        issued++;
      end else if (pick < 95) begin
        if ($urandom_range(0, 1) == 0) begin
          queue_req(KIND_DELAY, DELAY_W'($urandom_range(0, 20)),
                    OHANDLE_W'($urandom), calm);
        end else begin
          queue_req(KIND_DELAY, DELAY_W'($urandom), OHANDLE_W'($urandom), calm);
        end
        issued++;
      end else begin
        queue_req(KIND_UNUSED, DELAY_W'($urandom), OHANDLE_W'($urandom), calm);
        issued++;
      end
    end

    while (pending_reqs.size() != 0 || due_results.size() != 0) begin
      @(posedge clk);
    end
    // Any result that shows up now has no request behind it.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d checked results, %0d of them fired",
             accepted_reqs, results_checked, fired_count);
    $display("timeouts (longest burst %0d), with %0d adds refused on a full table.",
             longest_burst, reject_count);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
